[sv/tvna_pkg.sv]
// ----------------------------------------------------------------------------
// tvna_pkg
// Shared types, sizes and helpers for the tetrahedron volume node accumulator.
// ----------------------------------------------------------------------------
package tvna_pkg;

  localparam int NODES   = 1024;
  localparam int NODE_AW = $clog2(NODES);
  localparam int NODE_CW = 17;

  localparam logic [1:0] MODE_CORNER = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_NODE    = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [15:0] VOL_DIVISOR = 16'd6;

  // ceil(2^22 / 6): exact quotient of any 19-bit partial remainder by 6
  localparam logic [19:0] VOL_RECIP    = 20'd699051;
  localparam int          VOL_RECIP_SH = 22;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic [15:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a[63] && b[63] && !s[63]) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

endpackage

[sv/tvna_div.sv]
// ----------------------------------------------------------------------------
// tvna_div
// Radix-2 restoring divider: signed 64-bit dividend by unsigned 16-bit
// divisor, one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tvna_div (
  input  logic                clk,
  input  logic                rst,
  input  tvna_pkg::div_req_t  req,
  output tvna_pkg::div_stat_t stat,
  output logic signed [63:0]  quotient
);
  import tvna_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] q;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic        neg;
  logic [16:0] rem_sh;

  assign rem_sh = {rem[15:0], q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[63];
      q   <= req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[62:0], 1'b0};
      end
    end
  end

  assign quotient  = neg ? -$signed(q) : $signed(q);
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[sv/tetra_volume_node_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// tetra_volume_node_accumulator_unit
// Collects tetrahedron corners, forms the element volume with one shared
// multiplier and a digit-wise divide by six, and keeps per-node volume sums
// and counts; node averages use a serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                                    | dir
//  in      | in_valid/in_ready, mode, coord_*, node_id  | input word
//  out     | out_valid/out_ready, result_kind .. average| output word
//
//  Corners 0..2 and unused modes are taken in idle without leaving it. A fourth
//  corner runs the determinant (setup, then multiply, multiply, accumulate
//  per term on one multiplier), the divide by 6 (one 16-bit digit per
//  cycle by reciprocal multiply), four node table updates, then the emit.
//  A node read runs the 64-step average divider, which is skipped when the
//  count is zero.
//  After reset and a clear word, a pass zeroes all 1024 node table entries.
//  A result waits in the output register; a new result waits until it leaves.
module tetra_volume_node_accumulator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [9:0]         node_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic signed [52:0] element_volume,
  output logic signed [63:0] total_volume,
  output logic signed [63:0] node_sum,
  output logic [15:0]        node_count,
  output logic signed [63:0] node_average
);
  import tvna_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_MSET  = 14'b00000000000100,
    S_MUL_A = 14'b00000000001000,
    S_MUL_B = 14'b00000000010000,
    S_ACC   = 14'b00000000100000,
    S_VDIV  = 14'b00000001000000,
    S_UADDR = 14'b00000010000000,
    S_URD   = 14'b00000100000000,
    S_UWR   = 14'b00001000000000,
    S_RWAIT = 14'b00010000000000,
    S_RUSE  = 14'b00100000000000,
    S_AVG   = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic signed [15:0] cx [4];
  logic signed [15:0] cy [4];
  logic signed [15:0] cz [4];
  logic [9:0]         cnode [4];
  logic [1:0]         slot;

  logic signed [16:0] m [9];
  logic [2:0]         term;
  logic [1:0]         k;
  logic signed [16:0] ma, mb, mc;
  logic               tneg;
  logic signed [34:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [51:0] prod;
  logic signed [55:0] det;
  logic signed [55:0] det_next;

  logic [63:0]        vmag;
  logic               vneg;
  logic [2:0]         vrem;
  logic [1:0]         vdig;
  logic [18:0]        vpart;
  logic [38:0]        vprod;
  logic [15:0]        vqd;
  logic [2:0]         vrem_next;
  logic [63:0]        vmag_next;
  logic signed [63:0] vol_next;

  logic signed [63:0] vol;
  logic signed [63:0] total;
  logic               res_kind;
  logic signed [63:0] rd_sum;
  logic [15:0]        rd_cnt;
  logic signed [63:0] rd_avg;
  logic               rd_in_table;

  logic signed [63:0] sum_mem [NODES];
  logic [15:0]        cnt_mem [NODES];
  logic [NODE_AW-1:0] mem_addr;
  logic signed [63:0] rdata_sum;
  logic [15:0]        rdata_cnt;
  logic               mem_we;
  logic signed [63:0] wsum;
  logic [15:0]        wcnt;
  logic               node_ok;

  div_req_t           div_req;
  div_stat_t          div_stat;
  logic signed [63:0] div_q;

  logic in_fire;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  tvna_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // term operands of the cofactor expansion, one signed triple product each
  always_comb begin
    case (term)
      3'd0:    begin ma = m[0]; mb = m[4]; mc = m[8]; tneg = 1'b0; end
      3'd1:    begin ma = m[0]; mb = m[5]; mc = m[7]; tneg = 1'b1; end
      3'd2:    begin ma = m[1]; mb = m[3]; mc = m[8]; tneg = 1'b1; end
      3'd3:    begin ma = m[1]; mb = m[5]; mc = m[6]; tneg = 1'b0; end
      3'd4:    begin ma = m[2]; mb = m[3]; mc = m[7]; tneg = 1'b0; end
      default: begin ma = m[2]; mb = m[4]; mc = m[6]; tneg = 1'b1; end
    endcase
  end

  always_comb begin
    if (state == S_MUL_B) begin
      mul_a = prod[34:0];
      mul_b = mc;
    end else begin
      mul_a = 35'(ma);
      mul_b = mb;
    end
  end

  assign det_next = tneg ? det - 56'(prod) : det + 56'(prod);

  // divide the magnitude by 6 one 16-bit digit per cycle, top digit first
  assign vpart     = {vrem, vmag[63:48]};
  assign vprod     = {20'd0, vpart} * {19'd0, VOL_RECIP};
  assign vqd       = vprod[VOL_RECIP_SH +: 16];
  assign vrem_next = 3'(vpart - 19'(vqd) * 19'(VOL_DIVISOR));
  assign vmag_next = {vmag[47:0], vqd};
  assign vol_next  = vneg ? -$signed(vmag_next) : $signed(vmag_next);

  assign node_ok = {7'd0, cnode[k]} < NODE_CW'(NODES);

  always_comb begin
    mem_we = 1'b0;
    wsum   = '0;
    wcnt   = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_UWR && node_ok) begin
      mem_we = 1'b1;
      wsum   = sat_add(rdata_sum, vol);
      wcnt   = (rdata_cnt == COUNT_MAX) ? rdata_cnt : rdata_cnt + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_addr] <= wsum;
      cnt_mem[mem_addr] <= wcnt;
    end
    rdata_sum <= sum_mem[mem_addr];
    rdata_cnt <= cnt_mem[mem_addr];
  end

  always_comb begin
    div_req.dividend = rdata_sum;
    div_req.divisor  = rdata_cnt;
    div_req.start    = (state == S_RUSE) && rd_in_table && (rdata_cnt != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      mem_addr  <= '0;
      slot      <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          mem_addr <= mem_addr + 1'b1;
          if (mem_addr == NODE_AW'(NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            case (mode)
              MODE_CORNER: begin
                slot <= slot + 2'd1;
                if (slot == 2'd3) state <= S_MSET;
              end
              MODE_READ: begin
                mem_addr <= node_id[NODE_AW-1:0];
                state    <= S_RWAIT;
              end
              MODE_CLEAR: begin
                slot     <= '0;
                total    <= '0;
                mem_addr <= '0;
                state    <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MSET:  state <= S_MUL_A;
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_ACC;
        S_ACC:   state <= (term == 3'd5) ? S_VDIV : S_MUL_A;
        S_VDIV: begin
          if (vdig == 2'd3) begin
            total <= sat_add(total, vol_next);
            state <= S_UADDR;
          end
        end
        S_UADDR: begin
          mem_addr <= cnode[k][NODE_AW-1:0];
          state    <= S_URD;
        end
        S_URD: state <= S_UWR;
        S_UWR: state <= (k == 2'd3) ? S_EMIT : S_UADDR;
        S_RWAIT: state <= S_RUSE;
        S_RUSE: begin
          state <= (rd_in_table && rdata_cnt != 16'd0) ? S_AVG : S_EMIT;
        end
        S_AVG: if (div_stat.done) state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && mode == MODE_CORNER) begin
      cx[slot]    <= coord_x;
      cy[slot]    <= coord_y;
      cz[slot]    <= coord_z;
      cnode[slot] <= node_id;
    end
    if (in_fire && mode == MODE_READ) begin
      res_kind    <= KIND_NODE;
      rd_in_table <= {7'd0, node_id} < NODE_CW'(NODES);
    end
    if (state == S_MSET) begin
      for (int r = 0; r < 3; r++) begin
        m[r*3]   <= 17'(cx[r+1]) - 17'(cx[0]);
        m[r*3+1] <= 17'(cy[r+1]) - 17'(cy[0]);
        m[r*3+2] <= 17'(cz[r+1]) - 17'(cz[0]);
      end
      term     <= '0;
      det      <= '0;
      res_kind <= KIND_ELEMENT;
    end
    if (state == S_MUL_A || state == S_MUL_B) prod <= mul_a * mul_b;
    if (state == S_ACC) begin
      det  <= det_next;
      term <= term + 3'd1;
      if (term == 3'd5) begin
        vneg <= det_next[55];
        vmag <= det_next[55] ? 64'(-det_next) : 64'(det_next);
        vrem <= '0;
        vdig <= '0;
      end
    end
    if (state == S_VDIV) begin
      vmag <= vmag_next;
      vrem <= vrem_next;
      vdig <= vdig + 2'd1;
      if (vdig == 2'd3) begin
        vol <= vol_next;
        k   <= '0;
      end
    end
    if (state == S_UWR) k <= k + 2'd1;
    if (state == S_RUSE) begin
      rd_sum <= rd_in_table ? rdata_sum : 64'sd0;
      rd_cnt <= rd_in_table ? rdata_cnt : 16'd0;
      rd_avg <= '0;
    end
    if (state == S_AVG && div_stat.done) rd_avg <= div_q;
    if (state == S_EMIT && out_free) begin
      result_kind  <= res_kind;
      total_volume <= total;
      if (res_kind == KIND_ELEMENT) begin
        element_volume <= vol[52:0];
        node_sum       <= '0;
        node_count     <= '0;
        node_average   <= '0;
      end else begin
        element_volume <= '0;
        node_sum       <= rd_sum;
        node_count     <= rd_cnt;
        node_average   <= rd_avg;
      end
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE)) else $error("ready outside idle");
  a_write_only_clr_upd: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_UWR)) else $error("stray table write");
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_VDIV || state == S_AVG)) else $error("divider done unexpected");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> out_valid) else $error("result not presented");

endmodule
